/* src/ipfrt_pkg.sv */
// Shared types and constants for the IPv4 fragment reassembly tracker.
package ipfrt_pkg;

    localparam int MAX_FRAGMENTS = 8;
    localparam int IDX_W = $clog2(MAX_FRAGMENTS);
    localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);
    localparam int MARK_W = $clog2(MAX_FRAGMENTS * 65535 + 1);
    localparam int OFFSET_SHIFT = 3;

    typedef enum logic [2:0] {
        ST_IGNORED   = 3'd0,
        ST_STORED    = 3'd1,
        ST_COMPLETED = 3'd2,
        ST_LATE      = 3'd3,
        ST_STALE     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        logic [12:0] offset_units;
        logic        more_flag;
        logic [15:0] payload_bytes;
    } rec_t;

    typedef struct packed {
        logic              live;
        logic              done;
        logic [MARK_W-1:0] mark;
    } walk_t;

endpackage

/* src/ipfrt_cell.sv */
// One fragment record and its stage of the in-order completion walk.
module ipfrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  ipfrt_pkg::rec_t wr_rec,
    input  logic            in_table,
    input  ipfrt_pkg::walk_t walk_in,
    output ipfrt_pkg::walk_t walk_out
);

    ipfrt_pkg::rec_t  rec_reg;
    ipfrt_pkg::walk_t walk_reg;
    ipfrt_pkg::walk_t walk_next;

    logic [ipfrt_pkg::MARK_W-1:0] start_pos;
    logic [ipfrt_pkg::MARK_W-1:0] end_pos;

    assign start_pos = ipfrt_pkg::MARK_W'({rec_reg.offset_units,
                                           {ipfrt_pkg::OFFSET_SHIFT{1'b0}}});
    assign end_pos   = ipfrt_pkg::MARK_W'(walk_in.mark
                                          + ipfrt_pkg::MARK_W'(rec_reg.payload_bytes));

    always_comb begin
        walk_next = walk_in;
        if (!walk_in.done) begin
            walk_next.live = 1'b0;
            if (walk_in.live && in_table && start_pos == walk_in.mark) begin
                walk_next.mark = end_pos;
                if (rec_reg.more_flag) begin
                    walk_next.live = 1'b1;
                end else begin
                    walk_next.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_reg <= wr_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_reg.live <= 1'b0;
            walk_reg.done <= 1'b0;
        end else begin
            walk_reg.live <= walk_next.live;
            walk_reg.done <= walk_next.done;
        end
        walk_reg.mark <= walk_next.mark;
    end

    assign walk_out = walk_reg;

endmodule

/* src/ipv4_fragment_reassembly_tracker_top.sv */
// Top level: request decode, record bookkeeping and the chain of record cells.
//
// Usage:
//   s_ channel carries one fragment header per request (ident, addresses,
//   offset, more flag, payload length). m_ channel returns exactly one
//   result per request: status, total_bytes (nonzero only on completion)
//   and the number of records held afterwards.
//   A request is decoded and the table updated in S_DECIDE. If it stored
//   a record, a completion token then runs through the chain of
//   MAX_FRAGMENTS record cells, one cell per cycle, in S_WALK; any
//   other request goes straight from S_DECIDE to S_FINISH, where the
//   result is loaded. One request is in work at a time;
//   s_ready returns once the result is loaded into the output register,
//   so the next request may be accepted while the result waits.
//   For a stored request the rate is set by the walk along the cell chain.
//   Reset (aresetn low, synchronous) empties the table and clears the
//   current identification and first addresses. If m_ready stays low,
//   the finished next result waits until the output register is free.
module ipv4_fragment_reassembly_tracker_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_frag_ident,
    input  logic [31:0] s_source_addr,
    input  logic [31:0] s_dest_addr,
    input  logic [12:0] s_offset_units,
    input  logic        s_more_flag,
    input  logic [15:0] s_payload_bytes,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [18:0] m_total_bytes,
    output logic [3:0]  m_held_count
);

    localparam int N = ipfrt_pkg::MAX_FRAGMENTS;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_WALK   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] in_ident_reg;
    logic [31:0] in_src_reg;
    logic [31:0] in_dst_reg;
    ipfrt_pkg::rec_t in_rec_reg;

    logic [15:0] cur_ident_reg, cur_ident_next;
    logic [31:0] first_src_reg, first_src_next;
    logic [31:0] first_dst_reg, first_dst_next;
    logic [ipfrt_pkg::CNT_W-1:0] count_reg, count_next;
    ipfrt_pkg::status_t status_reg, status_next;
    logic [18:0] done_total_reg, done_total_next;
    logic walk_reg, walk_next;
    logic [ipfrt_pkg::IDX_W-1:0] step_reg, step_next;

    logic        m_valid_reg, m_valid_next;
    ipfrt_pkg::status_t m_status_reg, m_status_next;
    logic [18:0] m_total_reg, m_total_next;
    logic [3:0]  m_held_reg, m_held_next;

    logic write_rec;
    logic inject;
    logic out_free;
    ipfrt_pkg::walk_t chain [0:N];

    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign inject   = (state_reg == S_WALK) && (step_reg == '0);

    assign chain[0].live = inject;
    assign chain[0].done = 1'b0;
    assign chain[0].mark = '0;

    for (genvar k = 0; k < N; k++) begin : g_cell
        logic cell_wr;
        logic cell_in_table;
        assign cell_wr = write_rec
                         && (count_reg[ipfrt_pkg::IDX_W-1:0] == ipfrt_pkg::IDX_W'(k));
        assign cell_in_table = (ipfrt_pkg::CNT_W'(k) < count_reg);
        ipfrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (cell_wr),
            .wr_rec   (in_rec_reg),
            .in_table (cell_in_table),
            .walk_in  (chain[k]),
            .walk_out (chain[k+1])
        );
    end

    always_comb begin
        state_next      = state_reg;
        cur_ident_next  = cur_ident_reg;
        first_src_next  = first_src_reg;
        first_dst_next  = first_dst_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        done_total_next = done_total_reg;
        walk_next       = walk_reg;
        step_next       = step_reg;
        write_rec       = 1'b0;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_total_next    = m_total_reg;
        m_held_next     = m_held_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                status_next     = ipfrt_pkg::ST_IGNORED;
                done_total_next = '0;
                walk_next       = 1'b0;
                if (count_reg != '0) begin
                    if (in_ident_reg != cur_ident_reg && in_rec_reg.offset_units == '0) begin
                        count_next     = '0;
                        cur_ident_next = '0;
                        status_next    = ipfrt_pkg::ST_STALE;
                    end else if (in_ident_reg == cur_ident_reg
                                 && in_src_reg == first_src_reg
                                 && in_dst_reg == first_dst_reg) begin
                        if (count_reg >= ipfrt_pkg::CNT_W'(N)) begin
                            status_next = ipfrt_pkg::ST_FULL;
                        end else begin
                            write_rec   = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ipfrt_pkg::ST_STORED;
                            walk_next   = 1'b1;
                        end
                    end
                end else if (cur_ident_reg != '0 && in_ident_reg == cur_ident_reg) begin
                    status_next = ipfrt_pkg::ST_LATE;
                end else begin
                    cur_ident_next = in_ident_reg;
                    first_src_next = in_src_reg;
                    first_dst_next = in_dst_reg;
                    write_rec      = 1'b1;
                    count_next     = ipfrt_pkg::CNT_W'(1);
                    status_next    = ipfrt_pkg::ST_STORED;
                    walk_next      = 1'b1;
                end
                step_next  = '0;
                state_next = walk_next ? S_WALK : S_FINISH;
            end
            S_WALK: begin
                step_next = step_reg + 1'b1;
                if (step_reg == ipfrt_pkg::IDX_W'(N - 1)) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // chain output is valid for the first finish cycle only
                if (walk_reg && chain[N].done) begin
                    count_next      = '0;
                    status_next     = ipfrt_pkg::ST_COMPLETED;
                    done_total_next = 19'(chain[N].mark);
                    walk_next       = 1'b0;
                end
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_next;
                    m_total_next  = done_total_next;
                    m_held_next   = 4'(count_next);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_ident_reg              <= s_frag_ident;
            in_src_reg                <= s_source_addr;
            in_dst_reg                <= s_dest_addr;
            in_rec_reg.offset_units   <= s_offset_units;
            in_rec_reg.more_flag      <= s_more_flag;
            in_rec_reg.payload_bytes  <= s_payload_bytes;
        end
        status_reg     <= status_next;
        done_total_reg <= done_total_next;
        step_reg       <= step_next;
        m_status_reg   <= m_status_next;
        m_total_reg    <= m_total_next;
        m_held_reg     <= m_held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_ident_reg <= '0;
            first_src_reg <= '0;
            first_dst_reg <= '0;
            count_reg     <= '0;
            walk_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_ident_reg <= cur_ident_next;
            first_src_reg <= first_src_next;
            first_dst_reg <= first_dst_next;
            count_reg     <= count_next;
            walk_reg      <= walk_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_total_bytes = m_total_reg;
    assign m_held_count  = m_held_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ipfrt_pkg::CNT_W'(N))
        else $error("record count above table depth");

    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ipfrt_pkg::ST_COMPLETED |-> m_held_reg == '0)
        else $error("completion reported with records still held");

    a_total_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ipfrt_pkg::ST_COMPLETED |-> m_total_reg == '0)
        else $error("nonzero total without completion");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FINISH && !out_free |=> state_reg == S_FINISH)
        else $error("result left finish while output busy");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the IPv4 fragment reassembly tracker top level.
module tb;
    import ipfrt_pkg::*;

    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 30;

    typedef struct {
        status_t     status;
        logic [18:0] total;
        logic [3:0]  held;
    } outcome_t;

    typedef struct {
        logic [15:0] ident;
        logic [31:0] src;
        logic [31:0] dst;
        logic [12:0] off;
        logic        more;
        logic [15:0] len;
    } frag_t;

    class reassembly_checker;
        logic [15:0] cur_ident = '0;
        logic [31:0] first_src = '0;
        logic [31:0] first_dst = '0;
        rec_t        records[MAX_FRAGMENTS];
        int unsigned rec_count = 0;
        outcome_t    pending_outcomes[$];
        int unsigned errors = 0;

        function void append_record(frag_t f);
            records[rec_count].offset_units  = f.off;
            records[rec_count].more_flag     = f.more;
            records[rec_count].payload_bytes = f.len;
            rec_count++;
        endfunction

        function void take_fragment(frag_t f);
            outcome_t    o;
            logic        stored;
            int unsigned mark;
            int unsigned k;
            o.status = ST_IGNORED;
            o.total  = '0;
            stored   = 1'b0;
            if (rec_count > 0) begin
                if (f.ident != cur_ident && f.off == '0) begin
                    rec_count = 0;
                    cur_ident = '0;
                    o.status  = ST_STALE;
                end else if (f.ident == cur_ident && f.src == first_src &&
                             f.dst == first_dst) begin
                    if (rec_count >= MAX_FRAGMENTS) begin
                        o.status = ST_FULL;
                    end else begin
                        append_record(f);
                        o.status = ST_STORED;
                        stored   = 1'b1;
                    end
                end
            end else if (cur_ident != '0 && f.ident == cur_ident) begin
                o.status = ST_LATE;
            end else begin
                cur_ident = f.ident;
                first_src = f.src;
                first_dst = f.dst;
                append_record(f);
                o.status = ST_STORED;
                stored   = 1'b1;
            end
            // completion walk in arrival order
            if (stored) begin
                mark = 0;
                for (k = 0; k < rec_count; k++) begin
                    if ({records[k].offset_units, 3'b000} != mark) break;
                    mark += records[k].payload_bytes;
                    if (!records[k].more_flag) begin
                        o.status  = ST_COMPLETED;
                        o.total   = mark[18:0];
                        rec_count = 0;
                        break;
                    end
                end
            end
            o.held = 4'(rec_count);
            pending_outcomes.push_back(o);
        endfunction

        function void match_outcome(logic [2:0] st, logic [18:0] tot, logic [3:0] held);
            outcome_t o;
            if (pending_outcomes.size() == 0) begin
                $error("result with no request pending: status %0d", st);
                errors++;
            end else begin
                o = pending_outcomes.pop_front();
                if (st !== o.status) begin
                    $error("status: expected %0d, got %0d", o.status, st);
                    errors++;
                end
                if (tot !== o.total) begin
                    $error("total_bytes: expected %0d, got %0d", o.total, tot);
                    errors++;
                end
                if (held !== o.held) begin
                    $error("held_count: expected %0d, got %0d", o.held, held);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_frag_ident = '0;
    logic [31:0] s_source_addr = '0;
    logic [31:0] s_dest_addr = '0;
    logic [12:0] s_offset_units = '0;
    logic        s_more_flag = 1'b0;
    logic [15:0] s_payload_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [18:0] m_total_bytes;
    logic [3:0]  m_held_count;

    reassembly_checker sb = new;

    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left = 0;
    bit          hold_req = 1'b0;
    logic [15:0] last_ident = '0;

    ipv4_fragment_reassembly_tracker_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_frag_ident    (s_frag_ident),
        .s_source_addr   (s_source_addr),
        .s_dest_addr     (s_dest_addr),
        .s_offset_units  (s_offset_units),
        .s_more_flag     (s_more_flag),
        .s_payload_bytes (s_payload_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_total_bytes   (m_total_bytes),
        .m_held_count    (m_held_count)
    );

    always #2 aclk = ~aclk;

    function automatic frag_t mk_frag(logic [15:0] ident, logic [31:0] src,
                                      logic [31:0] dst, logic [12:0] off,
                                      logic more, logic [15:0] len);
        frag_t f;
        f.ident = ident;
        f.src   = src;
        f.dst   = dst;
        f.off   = off;
        f.more  = more;
        f.len   = len;
        return f;
    endfunction

    task automatic send_fragment(frag_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_frag_ident    <= f.ident;
        s_source_addr   <= f.src;
        s_dest_addr     <= f.dst;
        s_offset_units  <= f.off;
        s_more_flag     <= f.more;
        s_payload_bytes <= f.len;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // well-formed datagram with random content, sometimes broken on purpose
    task automatic send_datagram();
        frag_t       q[$];
        frag_t       f;
        logic [15:0] ident;
        logic [31:0] src;
        logic [31:0] dst;
        int unsigned n, i, mark_units, limit, step, pick, pick2;
        case ($urandom_range(7))
            0: ident = '0;
            1: ident = last_ident;
            default: ident = 16'($urandom_range(0, 65535));
        endcase
        src = $urandom();
        dst = $urandom();
        if ($urandom_range(9) == 0) n = MAX_FRAGMENTS + $urandom_range(1, 2);
        else n = $urandom_range(1, MAX_FRAGMENTS);
        mark_units = 0;
        for (i = 0; i < n; i++) begin
            limit = (8191 - mark_units) / (n - i);
            if ($urandom_range(1) == 0 && limit > 64) limit = 64;
            step = $urandom_range(0, limit);
            f.ident = ident;
            f.src   = src;
            f.dst   = dst;
            f.off   = 13'(mark_units);
            f.more  = (i != n - 1);
            f.len   = f.more ? 16'(step * 8) : 16'($urandom_range(0, 65535));
            if (f.more) mark_units += step;
            q.push_back(f);
        end
        if (q.size() >= 2 && $urandom_range(9) == 0) begin
            pick  = $urandom_range(0, q.size() - 1);
            pick2 = $urandom_range(0, q.size() - 1);
            f = q[pick];
            q[pick] = q[pick2];
            q[pick2] = f;
        end
        if (q.size() >= 2 && $urandom_range(11) == 0)
            q.delete($urandom_range(0, q.size() - 1));
        if ($urandom_range(9) == 0) begin
            pick = $urandom_range(0, q.size() - 1);
            q.insert(pick, q[pick]);
        end
        if ($urandom_range(9) == 0) begin
            f = q[$urandom_range(0, q.size() - 1)];
            case ($urandom_range(2))
                0: f.ident = f.ident ^ 16'($urandom_range(1, 65535));
                1: f.src = ~f.src;
                default: f.dst = f.dst ^ 32'h1;
            endcase
            if (q.size() >= 2) q.insert($urandom_range(1, q.size() - 1), f);
            else q.push_back(f);
        end
        if ($urandom_range(7) == 0) q.push_back(q[0]);
        foreach (q[k]) send_fragment(q[k]);
        last_ident = ident;
    endtask

    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.match_outcome(m_status, m_total_bytes, m_held_count);
            if (s_valid && s_ready)
                sb.take_fragment(mk_frag(s_frag_ident, s_source_addr, s_dest_addr,
                                         s_offset_units, s_more_flag, s_payload_bytes));
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        frag_t       f;
        int unsigned start, phase, i;
        bit          hold_done;
        hold_done = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // zero-length single fragment with ident zero
        send_fragment(mk_frag(16'h0000, 32'h0, 32'h0, 13'd0, 1'b0, 16'd0));
        send_fragment(mk_frag(16'h1234, 32'h0a000001, 32'h0a000002, 13'd0, 1'b1, 16'd16));
        send_fragment(mk_frag(16'h1234, 32'h0a000001, 32'h0a000002, 13'd2, 1'b1, 16'd16));
        send_fragment(mk_frag(16'h1234, 32'h0a000001, 32'h0a000002, 13'd4, 1'b0, 16'd100));
        // late duplicate
        send_fragment(mk_frag(16'h1234, 32'h0a000001, 32'h0a000002, 13'd0, 1'b1, 16'd16));
        send_fragment(mk_frag(16'hbeef, 32'hc0a80001, 32'hc0a80002, 13'd0, 1'b1, 16'd8));
        // foreign: address mismatches, other ident at nonzero offset
        send_fragment(mk_frag(16'hbeef, 32'hc0a80009, 32'hc0a80002, 13'd1, 1'b0, 16'd8));
        send_fragment(mk_frag(16'hbeef, 32'hc0a80001, 32'hc0a80009, 13'd1, 1'b0, 16'd8));
        send_fragment(mk_frag(16'habcd, 32'hc0a80001, 32'hc0a80002, 13'd5, 1'b0, 16'd8));
        // new datagram over old records
        send_fragment(mk_frag(16'habcd, 32'hc0a80001, 32'hc0a80002, 13'd0, 1'b1, 16'd8));
        // fill the table with records that never complete, then overflow
        for (i = 0; i < MAX_FRAGMENTS + 1; i++)
            send_fragment(mk_frag(16'hffff, 32'hffffffff, 32'hffffffff, 13'd8191,
                                  1'(i != 0), 16'hffff));
        send_fragment(mk_frag(16'hffff, 32'hffffffff, 32'hffffffff, 13'd0, 1'b0, 16'd0));
        send_fragment(mk_frag(16'h0000, 32'h0, 32'h0, 13'd0, 1'b0, 16'd0));
        // largest reachable total
        send_fragment(mk_frag(16'h0000, 32'h0, 32'h0, 13'd0, 1'b1, 16'd65528));
        send_fragment(mk_frag(16'h0000, 32'h0, 32'h0, 13'd8191, 1'b0, 16'hffff));

        start = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            phase = (items_sent - start) * 4 / RANDOM_ITEMS;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (!hold_done && items_sent - start >= 100) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(4) == 0) begin
                f.ident = $urandom_range(1) ? 16'($urandom_range(0, 65535)) : last_ident;
                f.src   = $urandom();
                f.dst   = $urandom();
                f.off   = $urandom_range(1) ? 13'd0 : 13'($urandom_range(0, 8191));
                f.more  = 1'($urandom_range(1));
                f.len   = 16'($urandom_range(0, 65535));
                send_fragment(f);
            end else begin
                send_datagram();
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
